[hw/rtl/bfa_pkg.sv]
`default_nettype none
package bfa_pkg;

   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;

   localparam logic [2:0] CMD_MARK_ALL = 3'd0;
   localparam logic [2:0] CMD_RELEASE  = 3'd1;
   localparam logic [2:0] CMD_RESERVE  = 3'd2;
   localparam logic [2:0] CMD_ALLOC    = 3'd3;
   localparam logic [2:0] CMD_FREE     = 3'd4;

   localparam logic [31:0] REGION_USABLE = 32'd1;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] region_type;
      logic [63:0] addr_first;
      logic [63:0] addr_second;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] alloc_addr;
      logic [18:0] free_frames;
      logic [31:0] top_frame;
   } rsp_type;

   // Control handed to the word update unit for one bitmap word.
   typedef struct packed {
      logic             alloc;
      logic             set;
      logic [BIT_W-1:0] lo_bit;
      logic [BIT_W-1:0] hi_bit;
   } word_ctrl_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] new_word;
      logic [BIT_W:0]       delta;
      logic                 hit;
      logic [BIT_W-1:0]     zero_pos;
   } word_res_type;

endpackage
`default_nettype wire

[hw/rtl/bitmap_frame_allocator_core.sv]
`default_nettype none
// First-fit physical frame allocator with one used bit per frame, held in a
// single-port-write, registered-read bitmap memory of 32-bit words. A command
// is taken when start is high and busy is low; its single result beat appears
// on rsp_data for exactly one cycle with rsp_valid high, and the receiver
// cannot stall it, so it must be captured then. Release, reserve and free
// pass each bitmap word touched through one read and one write of the memory
// port and the shared word update unit. Allocation scans from a hint word
// below which every word is known full, reading and writing each word
// scanned. Mark-all-used sweeps the memory at one word per cycle over all
// (NUM_FRAMES + 31) / 32 words, and the same sweep runs after reset, during
// which busy stays high.
module bitmap_frame_allocator_core #(
   parameter int NUM_FRAMES  = 262144,
   parameter int FRAME_SHIFT = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire bfa_pkg::req_type req_data,
   output logic                  rsp_valid,
   output bfa_pkg::rsp_type      rsp_data
);
   import bfa_pkg::*;

   localparam int WORD_COUNT = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int WCNT_W     = $clog2(WORD_COUNT + 1);
   localparam int FIDX_W     = $clog2(NUM_FRAMES);
   localparam logic [63:0] NF64 = 64'(NUM_FRAMES);
   localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORD_COUNT - 1);
   localparam logic [WCNT_W-1:0]  HINT_NONE = WCNT_W'(WORD_COUNT);

   typedef enum logic [5:0] {
      S_SWEEP = 6'b000001,
      S_IDLE  = 6'b000010,
      S_PREP  = 6'b000100,
      S_RD    = 6'b001000,
      S_WR    = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [63:0]        sum_ff, sum_in;
   logic [FIDX_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic               set_ff, set_in;
   logic               alloc_ff, alloc_in;
   logic               emit_ff, emit_in;
   logic [WADDR_W-1:0] word_ff, word_in;
   logic [18:0]        free_ff, free_in;
   logic [31:0]        top_ff, top_in;
   logic [WCNT_W-1:0]  hint_ff, hint_in;
   logic               ok_ff, ok_in;
   logic [31:0]        faddr_ff, faddr_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               ram_we;
   logic [31:0]        ram_wdata;
   logic [31:0]        ram_rdata;
   word_ctrl_type      wctrl;
   word_res_type       wres;

   // Frame numbers derived from the captured command.
   logic [63:0]        first_fr, second_fr, end_fr, stop_fr, resv_end;
   logic [WADDR_W-1:0] lo_word, hi_word;
   logic [63:0]        faddr_wide;

   assign first_fr  = req_ff.addr_first >> FRAME_SHIFT;
   assign second_fr = req_ff.addr_second >> FRAME_SHIFT;
   assign end_fr    = sum_ff >> FRAME_SHIFT;
   assign stop_fr   = (end_fr < NF64) ? end_fr : NF64;
   assign resv_end  = (second_fr >= NF64) ? (NF64 - 64'd1) : second_fr;
   assign lo_word   = WADDR_W'(lo_ff >> BIT_W);
   assign hi_word   = WADDR_W'(hi_ff >> BIT_W);
   assign faddr_wide = 64'({word_ff, wres.zero_pos}) << FRAME_SHIFT;

   assign wctrl.alloc  = alloc_ff;
   assign wctrl.set    = set_ff;
   assign wctrl.lo_bit = (word_ff == lo_word) ? lo_ff[BIT_W-1:0] : '0;
   assign wctrl.hi_bit = (word_ff == hi_word) ? hi_ff[BIT_W-1:0] : {BIT_W{1'b1}};

   bfa_word_unit u_word (
      .old_word (ram_rdata),
      .ctrl     (wctrl),
      .res      (wres)
   );

   assign ram_we    = (state_ff == S_SWEEP) || (state_ff == S_WR);
   assign ram_wdata = (state_ff == S_SWEEP) ? {WORD_BITS{1'b1}} : wres.new_word;

   bfa_bitmap_ram #(
      .DEPTH  (WORD_COUNT),
      .ADDR_W (WADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (word_ff),
      .wr_data (ram_wdata),
      .rd_addr (word_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      sum_in       = sum_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      set_in       = set_ff;
      alloc_in     = alloc_ff;
      emit_in      = emit_ff;
      word_in      = word_ff;
      free_in      = free_ff;
      top_in       = top_ff;
      hint_in      = hint_ff;
      ok_in        = ok_ff;
      faddr_in     = faddr_ff;
      rsp_valid_in = 1'b0;

      case (state_ff)
         S_SWEEP: begin
            // Every word is written all ones; the result beat follows only
            // when the sweep was commanded rather than caused by reset.
            if (word_ff == LAST_WORD) begin
               state_in = emit_ff ? S_DONE : S_IDLE;
            end else begin
               word_in = word_ff + WADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               sum_in   = req_data.addr_first + req_data.addr_second;
               ok_in    = 1'b1;
               faddr_in = '0;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            state_in = S_DONE;
            alloc_in = 1'b0;
            case (req_ff.cmd)
               CMD_MARK_ALL: begin
                  free_in  = '0;
                  hint_in  = HINT_NONE;
                  emit_in  = 1'b1;
                  word_in  = '0;
                  state_in = S_SWEEP;
               end
               CMD_RELEASE: begin
                  if (req_ff.region_type == REGION_USABLE) begin
                     if (end_fr[31:0] > top_ff) begin
                        top_in = end_fr[31:0];
                     end
                     if (first_fr < stop_fr) begin
                        lo_in    = FIDX_W'(first_fr);
                        hi_in    = FIDX_W'(stop_fr - 64'd1);
                        set_in   = 1'b0;
                        word_in  = WADDR_W'(first_fr >> BIT_W);
                        state_in = S_RD;
                        if (WCNT_W'(first_fr >> BIT_W) < hint_ff) begin
                           hint_in = WCNT_W'(first_fr >> BIT_W);
                        end
                     end
                  end
               end
               CMD_RESERVE: begin
                  if (first_fr <= resv_end) begin
                     lo_in    = FIDX_W'(first_fr);
                     hi_in    = FIDX_W'(resv_end);
                     set_in   = 1'b1;
                     word_in  = WADDR_W'(first_fr >> BIT_W);
                     state_in = S_RD;
                  end
               end
               CMD_ALLOC: begin
                  if (hint_ff >= HINT_NONE) begin
                     ok_in = 1'b0;
                  end else begin
                     alloc_in = 1'b1;
                     set_in   = 1'b1;
                     word_in  = WADDR_W'(hint_ff);
                     state_in = S_RD;
                  end
               end
               CMD_FREE: begin
                  if (first_fr < NF64) begin
                     lo_in    = FIDX_W'(first_fr);
                     hi_in    = FIDX_W'(first_fr);
                     set_in   = 1'b0;
                     word_in  = WADDR_W'(first_fr >> BIT_W);
                     state_in = S_RD;
                     if (WCNT_W'(first_fr >> BIT_W) < hint_ff) begin
                        hint_in = WCNT_W'(first_fr >> BIT_W);
                     end
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_RD: begin
            state_in = S_WR;
         end
         S_WR: begin
            if (alloc_ff) begin
               if (wres.hit) begin
                  free_in  = free_ff - 19'(wres.delta);
                  faddr_in = faddr_wide[31:0];
                  hint_in  = WCNT_W'(word_ff);
                  state_in = S_DONE;
               end else if (word_ff == LAST_WORD) begin
                  ok_in    = 1'b0;
                  hint_in  = HINT_NONE;
                  state_in = S_DONE;
               end else begin
                  word_in  = word_ff + WADDR_W'(1);
                  state_in = S_RD;
               end
            end else begin
               if (set_ff) begin
                  free_in = free_ff - 19'(wres.delta);
               end else begin
                  free_in = free_ff + 19'(wres.delta);
               end
               if (word_ff == hi_word) begin
                  state_in = S_DONE;
               end else begin
                  word_in  = word_ff + WADDR_W'(1);
                  state_in = S_RD;
               end
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            emit_in      = 1'b0;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         word_ff      <= '0;
         emit_ff      <= 1'b0;
         alloc_ff     <= 1'b0;
         free_ff      <= '0;
         top_ff       <= '0;
         hint_ff      <= HINT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         emit_ff      <= emit_in;
         alloc_ff     <= alloc_in;
         free_ff      <= free_in;
         top_ff       <= top_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      sum_ff   <= sum_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      set_ff   <= set_in;
      ok_ff    <= ok_in;
      faddr_ff <= faddr_in;
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data.ok          = ok_ff;
   assign rsp_data.alloc_addr  = faddr_ff;
   assign rsp_data.free_frames = free_ff;
   assign rsp_data.top_frame   = top_ff;

endmodule
`default_nettype wire

[hw/rtl/bfa_bitmap_ram.sv]
`default_nettype none
module bfa_bitmap_ram #(
   parameter int DEPTH  = 8192,
   parameter int ADDR_W = 13
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [31:0]       wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]            rd_data
);

   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[hw/rtl/bfa_word_unit.sv]
`default_nettype none
module bfa_word_unit (
   input  wire logic [31:0]           old_word,
   input  wire bfa_pkg::word_ctrl_type ctrl,
   output bfa_pkg::word_res_type      res
);
   import bfa_pkg::*;

   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] changed;
   logic [BIT_W-1:0]     pos;
   logic                 found;
   logic [BIT_W:0]       cnt;

   // Lowest clear bit of the word, for allocation.
   always_comb begin
      pos   = '0;
      found = 1'b0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!old_word[i]) begin
            pos   = BIT_W'(i);
            found = 1'b1;
         end
      end
   end

   always_comb begin
      if (ctrl.alloc) begin
         mask = found ? (WORD_BITS'(1) << pos) : '0;
      end else begin
         mask = ({WORD_BITS{1'b1}} << ctrl.lo_bit) &
                ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - ctrl.hi_bit));
      end
      changed = (ctrl.set || ctrl.alloc) ? (~old_word & mask) : (old_word & mask);
      cnt = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         cnt = cnt + (BIT_W + 1)'(changed[i]);
      end
      res.new_word = (ctrl.set || ctrl.alloc) ? (old_word | mask) : (old_word & ~mask);
      res.delta    = cnt;
      res.hit      = found;
      res.zero_pos = pos;
   end

endmodule
`default_nettype wire

[hw/rtl/bfa_checker.sv]
`default_nettype none
module bfa_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire bfa_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire bfa_pkg::rsp_type rsp_data
);

   logic unused_req;
   assign unused_req = ^req_data;

   // An accepted command keeps the block busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a command");

   // A result beat is only ever produced by a command that was in progress.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without a command in progress");

   // Each command yields one single-cycle result beat.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat lasted more than one cycle");

   // A failed allocation never reports a frame address.
   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> (rsp_data.alloc_addr == 32'd0))
      else $error("failed result carries a frame address");

endmodule

bind bitmap_frame_allocator_core bfa_checker u_bfa_checker (.*);
`default_nettype wire

[dv/bitmap_frame_allocator_core_tb.sv]
`timescale 1ns / 1ps
module bitmap_frame_allocator_core_tb;
   import bfa_pkg::*;

   localparam int NUM_FRAMES  = 262144;
   localparam int FRAME_SHIFT = 12;
   localparam int MAP_WORDS   = (NUM_FRAMES + 31) / 32;
   // The package names no code for a query; five to seven all behave as one.
   localparam logic [2:0] CMD_QUERY   = 3'd5;
   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;
   // Most random traffic works inside this many frames so that range commands stay short.
   localparam int POOL_FRAMES = 4096;
   localparam int RANDOM_BEATS = 1430;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   bitmap_frame_allocator_core #(
      .NUM_FRAMES  (NUM_FRAMES),
      .FRAME_SHIFT (FRAME_SHIFT)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Commands waiting to be driven, and the results that accepted commands must produce.
   req_type pending_cmds[$];
   rsp_type expected_rsps[$];
   int      beats_total;
   int      beats_sent;
   int      error_count;
   int      idle_pct;

   // The testbench's own image of the allocator: one used bit per frame in 32-bit words.
   logic [31:0] used_map [MAP_WORDS];
   logic [18:0] free_cnt;
   logic [31:0] top_mark;

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   function automatic void fill_map();
      foreach (used_map[i]) used_map[i] = '1;
      free_cnt = '0;
   endfunction

   // Sets or clears frames lo to hi inclusive, keeping the free count in step word by word.
   function automatic void mark_frames(longint unsigned lo, longint unsigned hi, bit set_bits);
      int          a;
      int          b;
      logic [31:0] mask;
      logic [31:0] old_w;
      logic [31:0] new_w;
      if (lo > hi || hi >= NUM_FRAMES) return;
      for (int w = int'(lo >> 5); w <= int'(hi >> 5); w++) begin
         a = (w == int'(lo >> 5)) ? int'(lo & 31) : 0;
         b = (w == int'(hi >> 5)) ? int'(hi & 31) : 31;
         mask = (32'hFFFF_FFFF >> (31 - (b - a))) << a;
         old_w = used_map[w];
         new_w = set_bits ? (old_w | mask) : (old_w & ~mask);
         used_map[w] = new_w;
         free_cnt = free_cnt + 19'($countones(old_w)) - 19'($countones(new_w));
      end
   endfunction

   function automatic rsp_type predict_alloc_result(req_type r);
      rsp_type         res;
      longint unsigned first_fr;
      longint unsigned end_fr;
      longint unsigned stop_fr;
      logic [31:0]     end_low;
      bit              found;
      int              bit_pos;
      res = '0;
      res.ok = 1'b1;
      case (r.cmd)
         CMD_MARK_ALL: fill_map();
         CMD_RELEASE: begin
            if (r.region_type == REGION_USABLE) begin
               first_fr = r.addr_first >> FRAME_SHIFT;
               end_fr   = (r.addr_first + r.addr_second) >> FRAME_SHIFT;
               stop_fr  = (end_fr < NUM_FRAMES) ? end_fr : NUM_FRAMES;
               end_low  = end_fr[31:0];
               if (first_fr < stop_fr) mark_frames(first_fr, stop_fr - 1, 1'b0);
               if (end_low > top_mark) top_mark = end_low;
            end
         end
         CMD_RESERVE: begin
            first_fr = r.addr_first >> FRAME_SHIFT;
            end_fr   = r.addr_second >> FRAME_SHIFT;
            if (end_fr >= NUM_FRAMES) end_fr = NUM_FRAMES - 1;
            if (first_fr <= end_fr) mark_frames(first_fr, end_fr, 1'b1);
         end
         CMD_ALLOC: begin
            found = 1'b0;
            for (int w = 0; w < MAP_WORDS && !found; w++) begin
               if (used_map[w] != 32'hFFFF_FFFF) begin
                  bit_pos = 0;
                  while (used_map[w][bit_pos]) bit_pos++;
                  first_fr = longint'(w) * 32 + bit_pos;
                  mark_frames(first_fr, first_fr, 1'b1);
                  res.alloc_addr = 32'(first_fr << FRAME_SHIFT);
                  found = 1'b1;
               end
            end
            if (!found) res.ok = 1'b0;
         end
         CMD_FREE: begin
            first_fr = r.addr_first >> FRAME_SHIFT;
            if (first_fr < NUM_FRAMES) mark_frames(first_fr, first_fr, 1'b0);
         end
         default: ;
      endcase
      res.free_frames = free_cnt;
      res.top_frame   = top_mark;
      return res;
   endfunction

   // The driver holds a command on the bus until the edge at which it is taken. That
   // same edge feeds the command to the predictor, then the next one (or an idle gap)
   // is put up. The idle rate moves through three phases as the run goes on.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(predict_alloc_result(req_data));
            beats_sent++;
         end
         if (beats_sent < beats_total / 3) idle_pct = 27;
         else if (beats_sent < 2 * beats_total / 3) idle_pct = 53;
         else idle_pct = 0;
         if (start && busy) begin
            // Still waiting for the block: the beat stays put.
         end else if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
            start    <= 1'b1;
            req_data <= pending_cmds.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // The monitor takes each result beat in its single valid cycle; it cannot be held.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("result beat with nothing expected at %0t", $realtime);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.ok !== want.ok) report_mismatch("ok", rsp_data.ok, want.ok);
            if (rsp_data.alloc_addr !== want.alloc_addr)
               report_mismatch("alloc_addr", rsp_data.alloc_addr, want.alloc_addr);
            if (rsp_data.free_frames !== want.free_frames)
               report_mismatch("free_frames", rsp_data.free_frames, want.free_frames);
            if (rsp_data.top_frame !== want.top_frame)
               report_mismatch("top_frame", rsp_data.top_frame, want.top_frame);
         end
      end
   end

   task automatic add_cmd(logic [2:0] c, logic [31:0] rt, logic [63:0] a, logic [63:0] b);
      req_type r;
      r.cmd         = c;
      r.region_type = rt;
      r.addr_first  = a;
      r.addr_second = b;
      pending_cmds.push_back(r);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] pool_addr();
      return (64'($urandom_range(POOL_FRAMES - 1)) << FRAME_SHIFT) | 64'($urandom_range(4095));
   endfunction

   initial begin
      int          pick;
      int          len;
      logic [63:0] base;
      fill_map();
      top_mark    = '0;
      error_count = 0;
      beats_sent  = 0;

      // Directed opening: the allocator comes out of reset with every frame used.
      add_cmd(CMD_QUERY, '0, '0, '0);
      add_cmd(CMD_ALLOC, '0, '0, '0);               // nothing free, so allocation fails
      add_cmd(CMD_RELEASE, REGION_USABLE, 64'h0, 64'h4_0000);
      add_cmd(CMD_RELEASE, 32'd2, 64'h10_0000, 64'h10_0000);  // not usable: ignored
      // Base near the top of the address space: the sum wraps to a low end, so neither the map nor the mark moves.
      add_cmd(CMD_RELEASE, REGION_USABLE, 64'hFFFF_FFFF_FFFF_F000, 64'h3000);
      add_cmd(CMD_RELEASE, REGION_USABLE, 64'h0123_4567_8000_0000, 64'h1000);
      // A region running past the last frame is clamped.
      add_cmd(CMD_RELEASE, REGION_USABLE, 64'(NUM_FRAMES - 40) << FRAME_SHIFT, 64'h4_0000);
      add_cmd(CMD_RESERVE, '0, 64'h5000, 64'h1000);  // start after end: no change
      add_cmd(CMD_RESERVE, '0, 64'(NUM_FRAMES - 10) << FRAME_SHIFT, '1);
      add_cmd(CMD_RESERVE, '0, 64'h3000, 64'h3FFF);
      add_cmd(CMD_ALLOC, '0, '0, '0);
      add_cmd(CMD_ALLOC, '0, '0, '0);
      add_cmd(CMD_FREE, '0, 64'h1000, '0);
      add_cmd(CMD_FREE, '0, 64'h1234, '0);           // already free
      add_cmd(CMD_FREE, '0, '1, '1);                 // beyond the last frame
      add_cmd(CMD_QUERY, '1, '1, '1);
      add_cmd(CMD_SPARE_A, '0, '1, '0);
      add_cmd(CMD_SPARE_B, '1, '0, '1);
      add_cmd(CMD_RELEASE, REGION_USABLE, 64'h0, 64'(NUM_FRAMES) << FRAME_SHIFT);
      add_cmd(CMD_ALLOC, '0, '0, '0);
      add_cmd(CMD_MARK_ALL, '1, '1, '1);
      add_cmd(CMD_QUERY, '0, '0, '0);
      add_cmd(CMD_RELEASE, REGION_USABLE, 64'h0, 64'(POOL_FRAMES) << FRAME_SHIFT);

      // Random part: mostly region, allocate and free traffic in the low pool, with
      // a share of wide random fields that exercise every bit at little cost.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            add_cmd(CMD_ALLOC, $urandom(), rand64(), rand64());
         end else if (pick < 55) begin
            add_cmd(CMD_FREE, $urandom(), pool_addr(), rand64());
         end else if (pick < 68) begin
            len = $urandom_range(200);
            base = pool_addr();
            add_cmd(CMD_RELEASE, REGION_USABLE, base,
                    64'(len) << FRAME_SHIFT | 64'($urandom_range(4095)));
         end else if (pick < 76) begin
            base = pool_addr();
            add_cmd(CMD_RESERVE, $urandom(), base, base + (64'($urandom_range(100)) << FRAME_SHIFT));
         end else if (pick < 81) begin
            add_cmd(CMD_QUERY + 3'($urandom_range(2)), $urandom(), rand64(), rand64());
         end else if (pick < 86) begin
            add_cmd(CMD_RELEASE, $urandom(), rand64(), rand64());
         end else if (pick < 90) begin
            add_cmd(CMD_RELEASE, REGION_USABLE, rand64() | 64'h8000_0000_0000_0000, rand64());
         end else if (pick < 94) begin
            add_cmd(CMD_RESERVE, $urandom(), rand64() | 64'h8000_0000_0000_0000, rand64());
         end else if (pick < 99) begin
            add_cmd(CMD_FREE, $urandom(), rand64(), rand64());
         end else begin
            // A rare full wipe, followed by a fresh pool so the traffic stays useful.
            add_cmd(CMD_MARK_ALL, $urandom(), rand64(), rand64());
            add_cmd(CMD_RELEASE, REGION_USABLE, 64'h0, 64'(POOL_FRAMES) << FRAME_SHIFT);
         end
      end
      beats_total = pending_cmds.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last command to be taken and every result to come back.
      do @(posedge clock); while (pending_cmds.size() > 0 || start);
      do @(posedge clock); while (expected_rsps.size() > 0);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("timeout at %0t", $realtime);
      $display("FAIL");
      $finish;
   end

endmodule
